// File: rtl/pai_pkg.sv
// ----------------------------------------------------------------------------
// pai_pkg
// Shared types and constants for the positional array insert/delete block.
// ----------------------------------------------------------------------------
package pai_pkg;

  localparam int DATA_W    = 32;
  localparam int CNT_W     = 7;
  localparam int POS_W     = 7;
  localparam int DEPTH_DEF = 64;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    K_LOAD   = 2'd0,
    K_DUMP   = 2'd1,
    K_INSERT = 2'd2,
    K_DELETE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    C_HOLD  = 3'd0,
    C_WRITE = 3'd1,
    C_INS   = 3'd2,
    C_DEL   = 3'd3,
    C_ROT   = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    data_t    wdata;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

endpackage

// File: rtl/pai_cell.sv
// ----------------------------------------------------------------------------
// pai_cell
// One slot. Holds a word; takes write data, or a neighbor's on shift/rotate.
// ----------------------------------------------------------------------------
module pai_cell #(
  parameter int INDEX = 0,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  pai_pkg::cell_cmd_t cmd,
  input  logic [AW-1:0]      idx,
  input  pai_pkg::data_t     left,
  input  pai_pkg::data_t     right,
  input  pai_pkg::data_t     head,
  output pai_pkg::data_t     q
);
  import pai_pkg::*;

  localparam logic [AW-1:0] MY = AW'(INDEX);

  always_ff @(posedge clk) begin
    case (cmd.op)
      C_WRITE: begin
        if (MY == idx) q <= cmd.wdata;
      end
      C_INS: begin
        if (MY == idx) q <= cmd.wdata;
        else if (MY > idx) q <= left;
      end
      C_DEL: begin
        if (MY >= idx) q <= right;
      end
      C_ROT: begin
        // idx marks the last occupied slot, which takes the head word
        if (MY == idx) q <= head;
        else q <= right;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/positional_array_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_array_insert_delete
// Ordered array of signed words with load, dump, insert and delete at position.
// ----------------------------------------------------------------------------
// The array is a row of DEPTH cells; load, insert and delete act on all cells
// at once and give one result beat each. A dump sends no beat when accepted,
// then rotates the occupied cells one step per cycle while the sink is not
// stalling and sends the head cell out, so a dump of N elements gives N beats;
// no new item is taken until its last beat is in the output register.
// Insert with a valid position, and load without start_req, on a full array
// report full and change nothing.
module positional_array_insert_delete #(
  parameter int DEPTH = pai_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // value[31:0], position[38:32], zero pad
  input  logic [2:0]  s_tuser,  // kind[1:0], start_req[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // element[31:0], fill_count[38:32], zero pad
  output logic [1:0]  m_tuser,  // status[1:0]
  output logic        m_tlast
);
  import pai_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam cnt_t DEPTH_C = CNT_W'(DEPTH);

  state_t    state, state_next;
  cnt_t      count, count_next;
  cnt_t      dcnt, dcnt_next;
  cell_cmd_t cmd;
  logic [AW-1:0] idx;
  data_t     cq [DEPTH];

  logic      out_load;
  status_t   out_status_next, out_status;
  data_t     out_elem_next, out_elem;
  logic      out_last_next, out_last;

  kind_t         in_kind;
  logic          in_start;
  data_t         in_value;
  logic [POS_W-1:0] in_pos;
  logic          accept, slot_free;
  cnt_t          base;
  logic [CNT_W:0] pos_x, cnt_x;

  assign in_kind  = kind_t'(s_tuser[1:0]);
  assign in_start = s_tuser[2];
  assign in_value = s_tdata[31:0];
  assign in_pos   = s_tdata[38:32];

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;

  assign pos_x = {1'b0, in_pos};
  assign cnt_x = {1'b0, count};
  assign base  = in_start ? '0 : count;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      pai_cell #(.INDEX(g), .AW(AW)) u_cell (
        .clk   (clk),
        .cmd   (cmd),
        .idx   (idx),
        .left  ((g == 0) ? in_value : cq[(g == 0) ? 0 : g-1]),
        .right ((g == DEPTH-1) ? cq[g] : cq[(g == DEPTH-1) ? g : g+1]),
        .head  (cq[0]),
        .q     (cq[g])
      );
    end
  endgenerate

  always_comb begin
    state_next      = state;
    count_next      = count;
    dcnt_next       = dcnt;
    cmd.op          = C_HOLD;
    cmd.wdata       = in_value;
    idx             = '0;
    out_load        = 1'b0;
    out_status_next = ST_OK;
    out_elem_next   = '0;
    out_last_next   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (in_kind)
            K_LOAD: begin
              if (base >= DEPTH_C) begin
                out_status_next = ST_FULL;
              end else begin
                cmd.op     = C_WRITE;
                idx        = base[AW-1:0];
                count_next = base + 1'b1;
              end
            end
            K_DUMP: begin
              if (count == '0) begin
                out_status_next = ST_EMPTY;
              end else begin
                out_load   = 1'b0;
                dcnt_next  = '0;
                state_next = S_DUMP;
              end
            end
            K_INSERT: begin
              if (count == '0) begin
                out_status_next = ST_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                out_status_next = ST_BADPOS;
              end else if (count >= DEPTH_C) begin
                out_status_next = ST_FULL;
              end else begin
                cmd.op     = C_INS;
                idx        = AW'(in_pos - 1'b1);
                count_next = count + 1'b1;
              end
            end
            K_DELETE: begin
              if (count == '0) begin
                out_status_next = ST_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x) begin
                out_status_next = ST_BADPOS;
              end else begin
                cmd.op     = C_DEL;
                idx        = AW'(in_pos - 1'b1);
                count_next = count - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_elem_next = cq[0];
          out_last_next = (dcnt == count - 1'b1);
          cmd.op        = C_ROT;
          idx           = AW'(count - 1'b1);
          dcnt_next     = dcnt + 1'b1;
          if (out_last_next) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      dcnt     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      dcnt  <= dcnt_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= out_status_next;
      out_elem   <= out_elem_next;
      out_last   <= out_last_next;
    end
  end

  assign m_tdata = {1'b0, count, out_elem};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("fill count above capacity");

  a_dump_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |=> (count == $past(count)))
    else $error("fill count changed during dump");

  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[38:32] == '0))
    else $error("empty status with nonzero fill count");

  a_dump_elem_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == ST_OK && state == S_DUMP))
    else $error("non-final beat outside dump");

endmodule

// File: tb/tb_positional_array_insert_delete.sv
// ----------------------------------------------------------------------------
// tb_positional_array_insert_delete
// Self-checking bench for the positional array insert/delete block.
// ----------------------------------------------------------------------------
// A short directed sequence covers empty, bad-position and ignored-field cases.
// Random traffic then grows the array to capacity, shrinks it and mixes all
// operations. Every accepted input beat updates a shadow array. The expected
// beats are queued and compared in order against the output stream. Both
// sides idle in random bursts, and the sink holds off once for a long
// stretch so that the block backs up.
module tb_positional_array_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  import pai_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int RAND_OPS   = 420;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 400;

  typedef struct {
    kind_t      kind;
    logic       start;
    data_t      value;
    logic [6:0] pos;
  } op_t;

  typedef struct {
    status_t status;
    data_t   element;
    logic    last;
    cnt_t    fill;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  op_t   pending_ops[$];
  beat_t expected_beats[$];
  data_t arr[DEPTH];
  int    arr_fill = 0;
  int    gen_fill = 0;
  int    total_ops = 0;
  int    taken_ops = 0;
  int    out_beats = 0;
  int    mismatches = 0;
  int    idle_cycles = 0;
  int    send_gap = 0;
  int    stall_left = 0;
  bit    long_done = 1'b0;
  logic  in_beat = 1'b0;
  logic  quiet;
  op_t   next_op;

  positional_array_insert_delete #(.DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  assign quiet = (total_ops > 0) && (taken_ops + 50 >= total_ops);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic data_t rand_value();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // queues one operation and tracks the fill level the generator expects
  task automatic add_op(input kind_t k, input logic st, input data_t v, input int p);
    op_t it;
    it.kind  = k;
    it.start = st;
    it.value = v;
    it.pos   = p[6:0];
    pending_ops.push_back(it);
    case (k)
      K_LOAD: begin
        if (st) gen_fill = 0;
        if (gen_fill < DEPTH) gen_fill++;
      end
      K_INSERT: begin
        if (gen_fill > 0 && p >= 1 && p <= gen_fill + 1 && gen_fill < DEPTH) gen_fill++;
      end
      K_DELETE: begin
        if (gen_fill > 0 && p >= 1 && p <= gen_fill) gen_fill--;
      end
      default: ;
    endcase
  endtask

  function automatic int pick_pos(input int hi);
    if (hi < 1 || $urandom_range(0, 6) == 0) return $urandom_range(0, 127);
    return $urandom_range(1, hi);
  endfunction

  // shadow array update; queues the beats this operation produces
  task automatic apply_op(input logic [2:0] user, input logic [39:0] data);
    kind_t k;
    logic  st;
    data_t v;
    int    p;
    beat_t b;
    k = kind_t'(user[1:0]);
    st = user[2];
    v = data[31:0];
    p = int'(data[38:32]);
    b.status = ST_OK;
    b.element = '0;
    b.last = 1'b1;
    case (k)
      K_LOAD: begin
        if (st) arr_fill = 0;
        if (arr_fill >= DEPTH) begin
          b.status = ST_FULL;
        end else begin
          arr[arr_fill] = v;
          arr_fill++;
        end
      end
      K_DUMP: begin
        if (arr_fill == 0) begin
          b.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < arr_fill; i++) begin
            b.element = arr[i];
            b.last = (i == arr_fill - 1);
            b.fill = cnt_t'(arr_fill);
            expected_beats.push_back(b);
          end
          return;
        end
      end
      K_INSERT: begin
        if (arr_fill == 0) begin
          b.status = ST_EMPTY;
        end else if (p < 1 || p > arr_fill + 1) begin
          b.status = ST_BADPOS;
        end else if (arr_fill >= DEPTH) begin
          b.status = ST_FULL;
        end else begin
          for (int i = arr_fill; i >= p; i--) arr[i] = arr[i-1];
          arr[p-1] = v;
          arr_fill++;
        end
      end
      default: begin
        if (arr_fill == 0) begin
          b.status = ST_EMPTY;
        end else if (p < 1 || p > arr_fill) begin
          b.status = ST_BADPOS;
        end else begin
          for (int i = p - 1; i < arr_fill - 1; i++) arr[i] = arr[i+1];
          arr_fill--;
        end
      end
    endcase
    b.fill = cnt_t'(arr_fill);
    expected_beats.push_back(b);
  endtask

  initial begin
    int r;
    int k;
    // directed
    add_op(K_DUMP,   1'b0, 32'h0, 0);
    add_op(K_INSERT, 1'b0, 32'h1234_5678, 1);
    add_op(K_DELETE, 1'b0, 32'h0, 1);
    add_op(K_LOAD,   1'b0, 32'h7FFF_FFFF, 0);
    add_op(K_LOAD,   1'b1, 32'h8000_0000, 127);
    add_op(K_LOAD,   1'b0, 32'h0000_0000, 0);
    add_op(K_LOAD,   1'b0, 32'hFFFF_FFFF, 0);
    add_op(K_INSERT, 1'b0, 32'h1111_1111, 0);
    add_op(K_INSERT, 1'b0, 32'h2222_2222, 5);
    add_op(K_INSERT, 1'b0, 32'h3333_3333, 127);
    add_op(K_INSERT, 1'b0, 32'hA5A5_A5A5, 1);
    add_op(K_INSERT, 1'b1, 32'h5A5A_5A5A, 5);
    add_op(K_INSERT, 1'b0, 32'hDEAD_BEEF, 3);
    add_op(K_DUMP,   1'b1, 32'hFFFF_FFFF, 127);
    add_op(K_DELETE, 1'b0, 32'h0, 0);
    add_op(K_DELETE, 1'b0, 32'h0, 7);
    add_op(K_DELETE, 1'b1, 32'hFFFF_FFFF, 127);
    add_op(K_DELETE, 1'b0, 32'hCAFE_F00D, 6);
    add_op(K_DELETE, 1'b0, 32'h0, 1);
    add_op(K_DELETE, 1'b0, 32'h0, 2);
    add_op(K_DUMP,   1'b0, 32'h0, 0);
    add_op(K_LOAD,   1'b1, 32'h0F0F_0F0F, 127);
    add_op(K_DELETE, 1'b0, 32'h0, 1);
    add_op(K_DUMP,   1'b0, 32'h0, 0);
    add_op(K_INSERT, 1'b0, 32'hFFFF_FFFF, 1);
    // random: grow to capacity, shrink, grow again, then mixed
    for (int n = 0; n < RAND_OPS; n++) begin
      r = $urandom_range(0, 99);
      if (n < 150 || (n >= 250 && n < 350)) begin
        k = (r < 45) ? 0 : (r < 75) ? 1 : (r < 85) ? 2 : 3;
      end else if (n < 250) begin
        k = (r < 15) ? 0 : (r < 30) ? 1 : (r < 80) ? 2 : 3;
      end else begin
        k = r % 4;
      end
      case (k)
        0: add_op(K_LOAD, $urandom_range(0, 99) < 3, rand_value(), $urandom_range(0, 127));
        1: add_op(K_INSERT, 1'($urandom_range(0, 1)), rand_value(), pick_pos(gen_fill + 1));
        2: add_op(K_DELETE, 1'($urandom_range(0, 1)), rand_value(), pick_pos(gen_fill));
        default: add_op(K_DUMP, 1'($urandom_range(0, 1)), rand_value(),
                        $urandom_range(0, 127));
      endcase
    end
    total_ops = pending_ops.size();

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (taken_ops < total_ops || expected_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("positional_array_insert_delete: match");
    end else begin
      $display("positional_array_insert_delete: mismatch");
    end
    $finish;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_beat) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_ops.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        s_tvalid <= 1'b0;
        send_gap <= $urandom_range(0, 18);
      end else begin
        next_op = pending_ops.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, next_op.pos, next_op.value};
        s_tuser <= {next_op.start, next_op.kind};
      end
    end
  end

  // sink: random stalls plus one long hold-off in the middle of the run
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!long_done && taken_ops >= 200) begin
      long_done <= 1'b1;
      m_tready <= 1'b0;
      stall_left <= LONG_HOLD;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    beat_t      want;
    logic [39:0] want_data;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        out_beats <= out_beats + 1;
        if (expected_beats.size() == 0) begin
          if (mismatches < 10)
            $display("beat %0d: unexpected status=%0d elem=%0d last=%0b fill=%0d",
                     out_beats, m_tuser, $signed(m_tdata[31:0]), m_tlast, m_tdata[38:32]);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          want_data = {1'b0, want.fill, want.element};
          if (m_tuser !== want.status || m_tdata !== want_data || m_tlast !== want.last) begin
            if (mismatches < 10) begin
              $write("beat %0d: expected status=%0d elem=%0d last=%0b fill=%0d, ",
                     out_beats, want.status, $signed(want.element), want.last, want.fill);
              $display("got status=%0d elem=%0d last=%0b fill=%0d pad=%0b",
                       m_tuser, $signed(m_tdata[31:0]), m_tlast, m_tdata[38:32],
                       m_tdata[39]);
            end
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_op(s_tuser, s_tdata);
        taken_ops <= taken_ops + 1;
      end
      in_beat <= s_tvalid && s_tready;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("positional_array_insert_delete: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
